// ===== rtl/core/wsu_pkg.sv =====
// Shared types and constants for the WebSocket text frame unmasker.
package wsu_pkg;

   localparam logic [3:0] OPCODE_TEXT = 4'd1;
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
   localparam logic [3:0] BASE_HEADER_LEN = 4'd2;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES = 4'd4;
   localparam logic [3:0] POS_OPCODE = 4'd0;
   localparam logic [3:0] POS_LENGTH = 4'd1;

   typedef enum logic [1:0] {
      KIND_WS = 2'd0,
      KIND_WSS = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_segment;
      logic       last_of_segment;
      logic       over_tls;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic       out_last;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } parse_result_type;

endpackage

// ===== rtl/core/wsu_if.sv =====
// Valid/ready stream interfaces for the request and response channels.
interface wsu_req_if import wsu_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

interface wsu_rsp_if import wsu_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/core/wsu_in_stage.sv =====
// Input register that holds one accepted request transaction.
module wsu_in_stage import wsu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   wsu_req_if.sink      req_if,
   input  logic         advance,
   output logic         stage_valid,
   output req_item_type stage_item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_if.ready = !valid_ff || advance;
   assign take = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_if.item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item = item_ff;

endmodule

// ===== rtl/core/wsu_parser.sv =====
// Frame header parser, key capture and payload unmasking state.
module wsu_parser import wsu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  req_item_type     item,
   output parse_result_type result
);

   logic [3:0]  pos_ff, pos_in;
   logic [3:0]  len_ff, len_in;
   logic        mask_ff, mask_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  phase_ff, phase_in;
   logic        rej_ff, rej_in;
   logic        secure_ff, secure_in;

   always_comb begin
      logic [3:0] pos;
      logic [3:0] len;
      logic [3:0] key_start;
      logic [3:0] key_off;
      logic [6:0] code;
      logic       emit;
      logic [7:0] obyte;

      pos = item.first_of_segment ? POS_OPCODE : pos_ff;
      len_in = item.first_of_segment ? BASE_HEADER_LEN : len_ff;
      mask_in = item.first_of_segment ? 1'b0 : mask_ff;
      key_in = item.first_of_segment ? 32'd0 : key_ff;
      phase_in = item.first_of_segment ? 2'd0 : phase_ff;
      rej_in = item.first_of_segment ? 1'b0 : rej_ff;
      secure_in = (item.first_of_segment || pos_ff == POS_OPCODE) ? item.over_tls : secure_ff;
      pos_in = pos;
      emit = 1'b0;
      obyte = 8'd0;
      code = item.data_byte[6:0];
      len = BASE_HEADER_LEN;
      key_start = len_in - KEY_BYTES;
      key_off = pos - key_start;

      if (rej_in) begin
         pos_in = pos;
      end else if (pos < len_in) begin
         if (pos == POS_OPCODE) begin
            if (item.data_byte[3:0] != OPCODE_TEXT) begin
               rej_in = 1'b1;
            end
         end else if (pos == POS_LENGTH) begin
            mask_in = item.data_byte[7];
            if (code == LEN_CODE_EXT16) begin
               len = len + EXT16_BYTES;
            end else if (code == LEN_CODE_EXT64) begin
               len = len + EXT64_BYTES;
            end
            if (item.data_byte[7]) begin
               len = len + KEY_BYTES;
            end
            len_in = len;
         end else if (mask_in && pos >= key_start) begin
            key_in[{key_off[1:0], 3'b000} +: 8] = item.data_byte;
         end
         pos_in = pos + 4'd1;
      end else begin
         obyte = item.data_byte ^ (mask_in ? key_in[{phase_in, 3'b000} +: 8] : 8'd0);
         phase_in = phase_in + 2'd1;
         emit = 1'b1;
      end

      result.valid = emit || item.last_of_segment;
      result.item.out_byte = obyte;
      result.item.out_kind = emit ? (secure_in ? KIND_WSS : KIND_WS) : KIND_REJECT;
      result.item.out_last = item.last_of_segment;

      if (item.last_of_segment) begin
         pos_in = POS_OPCODE;
         len_in = BASE_HEADER_LEN;
         mask_in = 1'b0;
         key_in = 32'd0;
         phase_in = 2'd0;
         rej_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_OPCODE;
         len_ff <= BASE_HEADER_LEN;
         mask_ff <= 1'b0;
         key_ff <= 32'd0;
         phase_ff <= 2'd0;
         rej_ff <= 1'b0;
         secure_ff <= 1'b0;
      end else if (advance) begin
         pos_ff <= pos_in;
         len_ff <= len_in;
         mask_ff <= mask_in;
         key_ff <= key_in;
         phase_ff <= phase_in;
         rej_ff <= rej_in;
         secure_ff <= secure_in;
      end
   end

endmodule

// ===== rtl/core/wsu_out_stage.sv =====
// Output register that holds one response transaction until it is taken.
module wsu_out_stage import wsu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  parse_result_type result,
   output logic             slot_free,
   wsu_rsp_if.source        rsp_if
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;
   logic         load;

   assign slot_free = !valid_ff || rsp_if.ready;
   assign load = advance && result.valid;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result.item;
      end
   end

   assign rsp_if.valid = valid_ff;
   assign rsp_if.item = item_ff;

endmodule

// ===== rtl/core/websocket_text_frame_unmask.sv =====
// Top level of the WebSocket text frame unmasker.
// The parse result of the input register is loaded into the output register.
// Throughput: one request transaction per cycle while the output is not stalled,
// set by the single parse stage between the input register and the output register.
// Reset is synchronous; it clears the parse state to the start of a header
// and empties both registers.
module websocket_text_frame_unmask import wsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wsu_req_if.sink    req_if,
   wsu_rsp_if.source  rsp_if
);

   logic             stage_valid;
   req_item_type     stage_item;
   logic             slot_free;
   logic             advance;
   parse_result_type result;

   assign advance = stage_valid && slot_free;

   wsu_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   wsu_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (stage_item),
      .result  (result)
   );

   wsu_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .slot_free (slot_free),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the WebSocket text frame unmasker: directed and random segments.
`timescale 1ns / 100ps

module testbench;
   import wsu_pkg::*;

   localparam int RANDOM_ITEMS   = 1000;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int DIRECTED_ROWS  = 24;
   localparam logic PIN  = 1'b1;
   localparam logic FREE = 1'b0;
   localparam rsp_item_type NO_RSP = '0;

   typedef struct packed {
      req_item_type req;
      logic         pinned;
      rsp_item_type rsp;
   } stim_row_type;

   // Fields: data byte, first, last, over TLS, pinned flag, then the pinned response.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      {8'h81, 1'b0, 1'b0, 1'b1, FREE, NO_RSP},
      {8'hFE, 1'b0, 1'b0, 1'b1, FREE, NO_RSP},
      {8'hFF, 1'b0, 1'b0, 1'b0, FREE, NO_RSP},
      {8'h00, 1'b0, 1'b0, 1'b1, FREE, NO_RSP},
      {8'h12, 1'b0, 1'b0, 1'b0, FREE, NO_RSP},
      {8'h34, 1'b0, 1'b0, 1'b1, FREE, NO_RSP},
      {8'h56, 1'b0, 1'b0, 1'b0, FREE, NO_RSP},
      {8'h78, 1'b0, 1'b0, 1'b1, FREE, NO_RSP},
      {8'hFF, 1'b0, 1'b0, 1'b0, FREE, NO_RSP},
      {8'h00, 1'b0, 1'b1, 1'b0, FREE, NO_RSP},
      {8'h82, 1'b1, 1'b0, 1'b0, FREE, NO_RSP},
      {8'h00, 1'b0, 1'b0, 1'b1, FREE, NO_RSP},
      {8'hFF, 1'b0, 1'b1, 1'b0, PIN, 8'h00, KIND_REJECT, 1'b1},
      {8'h01, 1'b1, 1'b0, 1'b1, FREE, NO_RSP},
      {8'h7F, 1'b0, 1'b1, 1'b1, PIN, 8'h00, KIND_REJECT, 1'b1},
      {8'h81, 1'b1, 1'b0, 1'b0, FREE, NO_RSP},
      {8'h00, 1'b0, 1'b0, 1'b0, FREE, NO_RSP},
      {8'hA5, 1'b0, 1'b0, 1'b1, FREE, NO_RSP},
      {8'h01, 1'b1, 1'b0, 1'b1, FREE, NO_RSP},
      {8'h7D, 1'b0, 1'b0, 1'b0, FREE, NO_RSP},
      {8'hFF, 1'b0, 1'b1, 1'b0, PIN, 8'hFF, KIND_WSS, 1'b1},
      {8'h81, 1'b1, 1'b1, 1'b1, PIN, 8'h00, KIND_REJECT, 1'b1},
      {8'hF1, 1'b0, 1'b0, 1'b0, FREE, NO_RSP},
      {8'h80, 1'b0, 1'b1, 1'b0, PIN, 8'h00, KIND_REJECT, 1'b1}
   };

   logic clock;
   logic reset;

   wsu_req_if req_bus ();
   wsu_rsp_if rsp_bus ();

   websocket_text_frame_unmask dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   stim_row_type stim_q [$];
   rsp_item_type expected_q [$];

   logic [3:0]  hdr_pos;
   logic [3:0]  hdr_len;
   logic        mask_on;
   logic [31:0] mask_word;
   logic [1:0]  key_phase;
   logic        frame_dropped;
   logic        secure;

   int error_count   = 0;
   int accepted_reqs = 0;
   int ws_count      = 0;
   int wss_count     = 0;
   int reject_count  = 0;
   int gap_left;
   int burst_left;
   int idle_cycles;
   int ready_mode;
   int ready_count;
   logic timed_out = 1'b0;

   function void clear_frame_state();
      hdr_pos       = POS_OPCODE;
      hdr_len       = BASE_HEADER_LEN;
      mask_on       = 1'b0;
      mask_word     = '0;
      key_phase     = '0;
      frame_dropped = 1'b0;
   endfunction

   function void unmask_step(input req_item_type r, output logic produced,
                             output rsp_item_type res);
      logic [3:0] key_base;
      logic [3:0] key_offset;
      logic [7:0] key_byte;
      produced = 1'b0;
      res = '0;
      if (r.first_of_segment) clear_frame_state();
      if (r.first_of_segment || hdr_pos == POS_OPCODE) secure = r.over_tls;
      if (frame_dropped) begin
      end else if (hdr_pos < hdr_len) begin
         key_base = hdr_len - KEY_BYTES;
         if (hdr_pos == POS_OPCODE) begin
            if (r.data_byte[3:0] != OPCODE_TEXT) frame_dropped = 1'b1;
         end else if (hdr_pos == POS_LENGTH) begin
            mask_on = r.data_byte[7];
            hdr_len = BASE_HEADER_LEN;
            if (r.data_byte[6:0] == LEN_CODE_EXT16) hdr_len = hdr_len + EXT16_BYTES;
            else if (r.data_byte[6:0] == LEN_CODE_EXT64) hdr_len = hdr_len + EXT64_BYTES;
            if (mask_on) hdr_len = hdr_len + KEY_BYTES;
         end else if (mask_on && hdr_pos >= key_base) begin
            key_offset = hdr_pos - key_base;
            mask_word[{key_offset[1:0], 3'b000} +: 8] = r.data_byte;
         end
         hdr_pos = hdr_pos + 4'd1;
      end else begin
         key_byte = mask_on ? mask_word[{key_phase, 3'b000} +: 8] : 8'h00;
         res.out_byte = r.data_byte ^ key_byte;
         res.out_kind = secure ? KIND_WSS : KIND_WS;
         res.out_last = r.last_of_segment;
         key_phase = key_phase + 2'd1;
         produced = 1'b1;
      end
      if (!produced && r.last_of_segment) begin
         produced = 1'b1;
         res.out_byte = 8'h00;
         res.out_kind = KIND_REJECT;
         res.out_last = 1'b1;
      end
      if (r.last_of_segment) clear_frame_state();
   endfunction

   // Mostly well-formed frames with random content; some noise and truncated segments.
   task automatic queue_random_segment();
      req_item_type seg [$];
      req_item_type it;
      stim_row_type row;
      logic         tls;
      logic         masked;
      logic [6:0]   code;
      logic [3:0]   opcode;
      logic [3:0]   upper;
      int           n_ext;
      int           n_pay;
      int           cut;
      if ($urandom_range(0, 99) < 6) begin
         n_pay = $urandom_range(1, 20);
         repeat (n_pay) begin
            it.data_byte        = 8'($urandom);
            it.first_of_segment = ($urandom_range(0, 4) == 0);
            it.last_of_segment  = ($urandom_range(0, 4) == 0);
            it.over_tls         = 1'($urandom);
            seg.push_back(it);
         end
      end else begin
         tls    = 1'($urandom);
         masked = 1'($urandom);
         upper  = 4'($urandom);
         opcode = ($urandom_range(0, 9) == 0) ? 4'($urandom) : OPCODE_TEXT;
         case ($urandom_range(0, 4))
            0: begin
               code = LEN_CODE_EXT16;
            end
            1: begin
               code = LEN_CODE_EXT64;
            end
            default: begin
               code = 7'($urandom_range(0, 125));
            end
         endcase
         n_ext = (code == LEN_CODE_EXT16) ? 2 : (code == LEN_CODE_EXT64) ? 8 : 0;
         n_pay = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 16);
         it = '0;
         it.over_tls  = tls;
         it.data_byte = {upper, opcode};
         seg.push_back(it);
         it.data_byte = {masked, code};
         seg.push_back(it);
         repeat (n_ext + (masked ? 4 : 0) + n_pay) begin
            it.data_byte = 8'($urandom);
            seg.push_back(it);
         end
         for (int i = 1; i < seg.size(); i++) begin
            if ($urandom_range(0, 4) == 0) seg[i].over_tls = ~tls;
         end
         seg[0].first_of_segment = ($urandom_range(0, 7) != 0);
         seg[seg.size() - 1].last_of_segment = 1'b1;
         if ($urandom_range(0, 11) == 0) begin
            cut = $urandom_range(1, seg.size());
            while (seg.size() > cut) void'(seg.pop_back());
            seg[seg.size() - 1].last_of_segment = 1'b0;
         end
      end
      foreach (seg[i]) begin
         row.req    = seg[i];
         row.pinned = FREE;
         row.rsp    = NO_RSP;
         stim_q.push_back(row);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_mode  <= 0;
         ready_count <= 0;
      end else begin
         if (ready_count == 0) begin
            ready_mode  <= $urandom_range(0, 2);
            ready_count <= $urandom_range(8, 64);
         end else begin
            ready_count <= ready_count - 1;
         end
         case (ready_mode)
            0: begin
               rsp_bus.ready <= 1'b1;
            end
            1: begin
               rsp_bus.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      stim_row_type row;
      rsp_item_type predicted;
      rsp_item_type want;
      logic         produced;
      logic         progress;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.item  <= '0;
         gap_left    = 0;
         burst_left  = 0;
         idle_cycles = 0;
         secure      = 1'b0;
         clear_frame_state();
      end else begin
         progress = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            progress = 1'b1;
            if (rsp_bus.item.out_kind == KIND_WS) ws_count++;
            else if (rsp_bus.item.out_kind == KIND_WSS) wss_count++;
            else reject_count++;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response byte %02h kind %0d last %0b", $time,
                        rsp_bus.item.out_byte, rsp_bus.item.out_kind, rsp_bus.item.out_last);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_bus.item.out_byte != want.out_byte ||
                   rsp_bus.item.out_kind != want.out_kind ||
                   rsp_bus.item.out_last != want.out_last) begin
                  $display("%0t: mismatch: expected byte %02h kind %0d last %0b,",
                           $time, want.out_byte, want.out_kind, want.out_last,
                           " got byte %02h kind %0d last %0b",
                           rsp_bus.item.out_byte, rsp_bus.item.out_kind,
                           rsp_bus.item.out_last);
                  error_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            progress = 1'b1;
            row = stim_q.pop_front();
            unmask_step(row.req, produced, predicted);
            if (produced) expected_q.push_back(row.pinned ? row.rsp : predicted);
            accepted_reqs++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0 || stim_q.size() == 0) begin
               req_bus.valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               req_bus.valid <= 1'b1;
               req_bus.item  <= stim_q[0].req;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
      end
   end

   initial begin
      stim_row_type row;
      reset = 1'b1;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED[i];
         stim_q.push_back(row);
      end
      while (stim_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) queue_random_segment();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (!timed_out && (stim_q.size() != 0 || expected_q.size() != 0))
         @(posedge clock);
      if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_q.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, expected_q.size());
      end
      $display("Sent %0d request bytes in directed and random segments,", accepted_reqs,
               " including noise and truncation.");
      $display("Checked %0d WS, %0d WSS and %0d reject responses.",
               ws_count, wss_count, reject_count);
      if (!timed_out && error_count == 0 && expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
